@@ hdl/ordered_array_insert_delete_unit_assert.svh @@
// assertion helpers for the ordered array unit
// both macros expect clk_i and rst_ni in the enclosing module
`ifndef ORDERED_ARRAY_INSERT_DELETE_UNIT_ASSERT_SVH
`define ORDERED_ARRAY_INSERT_DELETE_UNIT_ASSERT_SVH

// same-cycle implication
`define OAID_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OAID_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/oaid_pkg.sv @@
package oaid_pkg;

  localparam int unsigned LB_W = 6;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_READ   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  position;
    logic [31:0] value;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [6:0]  count;
  } result_t;

  // decision taken for an incoming item
  typedef struct packed {
    status_e status;
    logic    finish_now;
    logic    write_now;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    start_shift;
    logic    start_read;
    logic    is_insert;
  } plan_t;

endpackage

@@ hdl/oaid_ram.sv @@
module oaid_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ hdl/oaid_check.sv @@
module oaid_check #(
  parameter int unsigned CAPACITY = 64
) (
  input  oaid_pkg::item_t                          item_i,
  input  logic [oaid_pkg::LB_W-1:0]                lb_i,
  input  logic [$clog2(CAPACITY+1)-1:0]            cnt_i,
  output oaid_pkg::plan_t                          plan_o,
  output logic [((($clog2(CAPACITY+1) > 6) ? $clog2(CAPACITY+1) : 6) + 1)-1:0] top_o
);
  import oaid_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY+1);
  localparam int unsigned CMP_W = ((CNT_W > 6) ? CNT_W : 6) + 1;

  logic [CMP_W-1:0] pos_w;
  logic [CMP_W-1:0] lb_w;
  logic [CMP_W-1:0] top_w;
  logic [CMP_W-1:0] cap_w;

  assign pos_w = CMP_W'(item_i.position);
  assign lb_w  = CMP_W'(lb_i);
  assign top_w = lb_w + CMP_W'(cnt_i);
  assign cap_w = CMP_W'(CAPACITY);
  assign top_o = top_w;

  always_comb begin
    plan_o = '0;
    plan_o.status = ST_DONE;
    unique case (kind_e'(item_i.kind))
      KIND_INSERT: begin
        plan_o.is_insert = 1'b1;
        if (pos_w < lb_w || pos_w > top_w) begin
          plan_o.status     = ST_RANGE;
          plan_o.finish_now = 1'b1;
        end else if (top_w >= cap_w) begin
          plan_o.status     = ST_FULL;
          plan_o.finish_now = 1'b1;
        end else if (pos_w == top_w) begin
          // append, nothing to move
          plan_o.finish_now = 1'b1;
          plan_o.write_now  = 1'b1;
          plan_o.cnt_inc    = 1'b1;
        end else begin
          plan_o.start_shift = 1'b1;
        end
      end
      KIND_DELETE: begin
        if (pos_w < lb_w || pos_w >= top_w || top_w > cap_w) begin
          plan_o.status     = ST_RANGE;
          plan_o.finish_now = 1'b1;
        end else if (pos_w + CMP_W'(1) == top_w) begin
          // last element, just drop it
          plan_o.finish_now = 1'b1;
          plan_o.cnt_dec    = 1'b1;
        end else begin
          plan_o.start_shift = 1'b1;
        end
      end
      KIND_READ: begin
        if (pos_w < lb_w || pos_w >= top_w || pos_w >= cap_w) begin
          plan_o.status     = ST_RANGE;
          plan_o.finish_now = 1'b1;
        end else begin
          plan_o.start_read = 1'b1;
        end
      end
      default: begin
        plan_o.status     = ST_RANGE;
        plan_o.finish_now = 1'b1;
      end
    endcase
  end

endmodule

@@ hdl/ordered_array_insert_delete_unit.sv @@
// ordered array with insert, delete and read at an absolute slot position
//
// command channel: item_i is taken on a rising edge with start_i high and
// busy_o low. every item gives exactly one result on result_o, shown for one
// cycle with done_o high; the receiver takes it on that edge and cannot stall.
// config: cfg_we_i writes lower_bound from cfg_wdata_i; the write is dropped
// while the array holds elements or when the value is not below CAPACITY.
//
// a rejected item, an append insert and a delete of the last element are
// settled without a busy state; a read goes through S_READ for its registered
// memory read; an insert at pos moves the elements from pos to top-1 up one
// slot, then writes the new value in S_FILL; a delete at pos moves the
// elements from pos+1 to top-1 down one slot, where top = lower_bound + count.
// the cost is set by the element memory with one read and one write port:
// each moved element is read and then written, and an insert writes the new
// value after the moves. busy_o stays high while a move or read runs.
//
// reset clears the count, lower_bound and the state machine; memory contents
// are left as they are, since only slots holding elements are ever read.
module ordered_array_insert_delete_unit #(
  parameter int unsigned CAPACITY      = 64,
  parameter int unsigned ELEMENT_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  oaid_pkg::item_t               item_i,
  output logic                          busy_o,
  output logic                          done_o,
  output oaid_pkg::result_t             result_o,
  input  logic                          cfg_we_i,
  input  logic [oaid_pkg::LB_W-1:0]     cfg_wdata_i
);
  import oaid_pkg::*;

  `include "ordered_array_insert_delete_unit_assert.svh"

  localparam int unsigned AW    = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY+1);
  localparam int unsigned CMP_W = ((CNT_W > 6) ? CNT_W : 6) + 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SHIFT = 4'b0010,
    S_FILL  = 4'b0100,
    S_READ  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // control state
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [LB_W-1:0]  lb_q, lb_d;
  logic             done_q, done_d;

  // per-item working registers
  logic [AW-1:0]            wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]            rd_ptr_q, rd_ptr_d;
  logic [AW-1:0]            stop_q, stop_d;
  logic [AW-1:0]            pos_q, pos_d;
  logic [ELEMENT_WIDTH-1:0] val_q, val_d;
  logic                     ins_q, ins_d;
  result_t                  res_q, res_d;

  // memory port signals
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [ELEMENT_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]            ram_raddr;
  logic [ELEMENT_WIDTH-1:0] ram_rdata;

  plan_t            plan;
  logic [CMP_W-1:0] top_w;
  logic             accept;
  logic [AW-1:0]    item_pos;
  logic [ELEMENT_WIDTH-1:0] item_val;
  logic [63:0]      rdata_wide;

  assign busy_o   = (state_q != S_IDLE);
  assign accept   = start_i && !busy_o;
  assign item_pos = AW'(item_i.position);
  assign item_val = ELEMENT_WIDTH'(64'(item_i.value));
  assign rdata_wide = 64'(ram_rdata);

  oaid_check #(
    .CAPACITY(CAPACITY)
  ) u_check (
    .item_i(item_i),
    .lb_i  (lb_q),
    .cnt_i (cnt_q),
    .plan_o(plan),
    .top_o (top_w)
  );

  oaid_ram #(
    .WIDTH(ELEMENT_WIDTH),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // lower bound is only writable while empty and below capacity
  always_comb begin
    lb_d = lb_q;
    if (cfg_we_i && cnt_q == '0 && CMP_W'(cfg_wdata_i) < CMP_W'(CAPACITY)) begin
      lb_d = cfg_wdata_i;
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    done_d    = 1'b0;
    res_d     = res_q;
    wr_ptr_d  = wr_ptr_q;
    rd_ptr_d  = rd_ptr_q;
    stop_d    = stop_q;
    pos_d     = pos_q;
    val_d     = val_q;
    ins_d     = ins_q;
    ram_we    = 1'b0;
    ram_waddr = wr_ptr_q;
    ram_wdata = ram_rdata;
    ram_raddr = rd_ptr_q;

    unique case (state_q)
      S_IDLE: begin
        ram_raddr = item_pos;
        if (accept) begin
          pos_d = item_pos;
          val_d = item_val;
          ins_d = plan.is_insert;
          if (plan.finish_now) begin
            // result straight away: rejects, append, drop of last element
            done_d           = 1'b1;
            res_d.status     = plan.status;
            res_d.read_value = '0;
            if (plan.write_now) begin
              ram_we    = 1'b1;
              ram_waddr = item_pos;
              ram_wdata = item_val;
            end
            if (plan.cnt_inc) begin
              cnt_d = cnt_q + CNT_W'(1);
            end else if (plan.cnt_dec) begin
              cnt_d = cnt_q - CNT_W'(1);
            end
          end else if (plan.start_shift) begin
            state_d = S_SHIFT;
            if (plan.is_insert) begin
              // move up: slot i takes slot i-1, from the top down to pos+1
              ram_raddr = AW'(top_w - CMP_W'(1));
              wr_ptr_d  = AW'(top_w);
              rd_ptr_d  = AW'(top_w - CMP_W'(2));
              stop_d    = item_pos + AW'(1);
            end else begin
              // move down: slot i takes slot i+1, from pos up to top-2
              ram_raddr = item_pos + AW'(1);
              wr_ptr_d  = item_pos;
              rd_ptr_d  = item_pos + AW'(2);
              stop_d    = AW'(top_w - CMP_W'(2));
            end
          end else if (plan.start_read) begin
            state_d = S_READ;
          end
        end
      end
      S_SHIFT: begin
        // write the element read last cycle, issue the next read
        ram_we = 1'b1;
        if (ins_q) begin
          wr_ptr_d = wr_ptr_q - AW'(1);
          rd_ptr_d = rd_ptr_q - AW'(1);
        end else begin
          wr_ptr_d = wr_ptr_q + AW'(1);
          rd_ptr_d = rd_ptr_q + AW'(1);
        end
        if (wr_ptr_q == stop_q) begin
          if (ins_q) begin
            state_d = S_FILL;
          end else begin
            state_d          = S_IDLE;
            done_d           = 1'b1;
            res_d.status     = ST_DONE;
            res_d.read_value = '0;
            cnt_d            = cnt_q - CNT_W'(1);
          end
        end
      end
      S_FILL: begin
        // gap is open, drop the new value in
        ram_we           = 1'b1;
        ram_waddr        = pos_q;
        ram_wdata        = val_q;
        state_d          = S_IDLE;
        done_d           = 1'b1;
        res_d.status     = ST_DONE;
        res_d.read_value = '0;
        cnt_d            = cnt_q + CNT_W'(1);
      end
      S_READ: begin
        state_d          = S_IDLE;
        done_d           = 1'b1;
        res_d.status     = ST_DONE;
        res_d.read_value = rdata_wide[31:0];
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_d.count = 7'(cnt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      lb_q    <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      lb_q    <= lb_d;
      done_q  <= done_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    wr_ptr_q <= wr_ptr_d;
    rd_ptr_q <= rd_ptr_d;
    stop_q   <= stop_d;
    pos_q    <= pos_d;
    val_q    <= val_d;
    ins_q    <= ins_d;
    res_q    <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // a move always keeps the block busy on the following cycle
  `OAID_ASSERT_NXT(a_shift_busy, accept && plan.start_shift, busy_o, "move did not start")
  // the reported count is the count held after the transfer
  `OAID_ASSERT_IMP(a_count_match, done_o, result_o.count == 7'(cnt_q), "count mismatch")
  // the count only moves together with a result
  `OAID_ASSERT_IMP(a_count_with_done, !$stable(cnt_q), done_o, "count moved without result")
  // lower bound only changes while the array was empty
  `OAID_ASSERT_IMP(a_lb_when_empty, !$stable(lb_q), $past(cnt_q) == '0, "lower bound moved")

endmodule

@@ bench/ordered_array_insert_delete_unit_tb.sv @@
module ordered_array_insert_delete_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import oaid_pkg::*;

  localparam int unsigned CAPACITY      = 64;
  localparam int unsigned ELEMENT_WIDTH = 32;
  // kind encoding the block must reject
  localparam logic [1:0]  KIND_UNUSED   = 2'd3;
  // quiet window after the last result, longer than the worst slot shuffle
  localparam int unsigned DRAIN_CYCLES  = 80;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_ITEMS   = 150;

  // shadow copy of the array plus the queue of results still owed by the block
  class shadow_array;
    logic [31:0] cells [CAPACITY];
    int unsigned held;
    int unsigned base;
    result_t     results_due [$];
    int unsigned mismatches;

    function new();
      held = 0;
      base = 0;
      mismatches = 0;
      foreach (cells[i]) cells[i] = '0;
    endfunction

    // lower bound only moves while the array is empty
    function void write_base(logic [5:0] v);
      if (held == 0 && v < CAPACITY) base = v;
    endfunction

    // outcome of one operation, updating the shadow state on the way
    function result_t apply_operation(item_t op);
      result_t     r;
      int unsigned top;
      int unsigned i;
      r = '0;
      r.status = ST_RANGE;
      top = base + held;
      case (op.kind)
        KIND_INSERT: begin
          // range check comes before the full check
          if (op.position >= base && op.position <= top) begin
            if (top >= CAPACITY) begin
              r.status = ST_FULL;
            end else begin
              for (i = top; i > op.position; i--) cells[i] = cells[i - 1];
              cells[op.position] = op.value;
              held++;
              r.status = ST_DONE;
            end
          end
        end
        KIND_DELETE: begin
          if (op.position >= base && op.position < top) begin
            for (i = op.position; i + 1 < top; i++) cells[i] = cells[i + 1];
            held--;
            r.status = ST_DONE;
          end
        end
        KIND_READ: begin
          if (op.position >= base && op.position < top) begin
            r.status = ST_DONE;
            r.read_value = cells[op.position];
          end
        end
        default: ;
      endcase
      r.count = 7'(held);
      return r;
    endfunction

    function void note_transfer(item_t op);
      results_due.push_back(apply_operation(op));
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (results_due.size() == 0) begin
        report_mismatch($sformatf("result with nothing owed: status %0d value %h count %0d",
                                  got.status, got.read_value, got.count));
        return;
      end
      want = results_due.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.read_value !== want.read_value)
        report_mismatch($sformatf("read_value %h, want %h", got.read_value, want.read_value));
      if (got.count !== want.count)
        report_mismatch($sformatf("count %0d, want %0d", got.count, want.count));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  item_t       item_i;
  logic        busy_o;
  logic        done_o;
  result_t     result_o;
  logic        cfg_we_i;
  logic [LB_W-1:0] cfg_wdata_i;

  shadow_array sb = new();
  int unsigned cycle_count;

  ordered_array_insert_delete_unit #(
    .CAPACITY      (CAPACITY),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .item_i      (item_i),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // result side: the strobe is valid for exactly one cycle, no stalling possible
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(result_o);
  end

  // hold start until the block takes the transfer; start is left high on return
  task automatic send_item(item_t op);
    start_i <= 1'b1;
    item_i  <= op;
    do @(posedge clk_i); while (busy_o);
    sb.note_transfer(op);
  endtask

  task automatic send_op(logic [1:0] kind, logic [5:0] pos, logic [31:0] value);
    item_t op;
    op.kind     = kind;
    op.position = pos;
    op.value    = value;
    send_item(op);
  endtask

  // random sender gap with start low, taken with a 25 percent chance when gaps are on
  task automatic maybe_idle(bit gaps_on);
    if (gaps_on && $urandom_range(99) < 25) begin
      start_i <= 1'b0;
      repeat ($urandom_range(10, 1)) @(posedge clk_i);
    end
  endtask

  // register write once nothing is owed and the block is quiet
  task automatic set_base_slot(logic [5:0] v);
    start_i <= 1'b0;
    while (sb.results_due.size() != 0 || busy_o) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.write_base(v);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // mostly legal positions with random content, some noise anywhere
  task automatic send_random_op(int unsigned insert_pct);
    item_t       op;
    int unsigned lo;
    int unsigned top;
    int unsigned pick;
    lo  = sb.base;
    top = sb.base + sb.held;
    pick = $urandom_range(99);
    if (pick < 3) op.kind = KIND_UNUSED;
    else if ($urandom_range(99) < insert_pct) op.kind = KIND_INSERT;
    else if ($urandom_range(1) == 1) op.kind = KIND_DELETE;
    else op.kind = KIND_READ;

    pick = $urandom_range(99);
    if (pick < 10) begin
      op.position = 6'($urandom_range(63));
    end else if (op.kind == KIND_INSERT || op.kind == KIND_UNUSED) begin
      // append slot included; a full array has no append slot in range
      op.position = 6'((top > CAPACITY - 1) ? $urandom_range(CAPACITY - 1, lo)
                                            : $urandom_range(top, lo));
    end else if (sb.held == 0) begin
      op.position = 6'($urandom_range(63));
    end else begin
      op.position = 6'($urandom_range(top - 1, lo));
    end

    pick = $urandom_range(99);
    if (pick < 10) op.value = '0;
    else if (pick < 20) op.value = '1;
    else op.value = $urandom;
    send_item(op);
  endtask

  logic [5:0]  phase_base [PHASES];
  int unsigned phase_insert_pct [PHASES];
  bit          phase_gaps [PHASES];

  initial begin
    start_i     <= 1'b0;
    item_i      <= '0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    rst_ni      <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty array with the reset lower bound of zero
    send_op(KIND_READ,   6'd0, 32'h0);           // read while empty
    send_op(KIND_DELETE, 6'd0, 32'h0);           // delete while empty
    send_op(KIND_INSERT, 6'd1, 32'h1234_5678);   // insert above append slot
    send_op(KIND_INSERT, 6'd0, 32'h0000_0000);
    send_op(KIND_INSERT, 6'd1, 32'hFFFF_FFFF);   // append
    send_op(KIND_INSERT, 6'd0, 32'h5A5A_A5A5);   // insert at front shifts both up
    send_op(KIND_READ,   6'd0, 32'h0);
    send_op(KIND_READ,   6'd1, 32'hFFFF_FFFF);
    send_op(KIND_READ,   6'd2, 32'h0);
    send_op(KIND_READ,   6'd3, 32'h0);           // one past the last element
    send_op(KIND_UNUSED, 6'd0, 32'h0);           // unknown kind
    send_op(KIND_DELETE, 6'd1, 32'h0);           // middle delete shifts down
    send_op(KIND_DELETE, 6'd1, 32'h0);           // delete of the last element
    send_op(KIND_READ,   6'd1, 32'h0);
    // lower bound write dropped while elements are held
    set_base_slot(6'd63);
    send_op(KIND_READ,   6'd0, 32'h0);
    send_op(KIND_DELETE, 6'd0, 32'h0);           // array empty again
    // top lower bound leaves room for a single element
    set_base_slot(6'd63);
    send_op(KIND_INSERT, 6'd62, 32'h0BAD_F00D);  // below the lower bound
    send_op(KIND_INSERT, 6'd63, $urandom);
    send_op(KIND_INSERT, 6'd63, $urandom);       // full array
    send_op(KIND_READ,   6'd63, 32'h0);
    send_op(KIND_READ,   6'd62, 32'h0);
    send_op(KIND_DELETE, 6'd63, 32'h0);          // empties the array
    send_op(KIND_DELETE, 6'd63, 32'h0);

    // random phases, each with its own lower bound and insert bias
    phase_base       = '{6'd0, 6'd63, 6'd37, 6'd1, 6'd62, 6'($urandom_range(63)),
                         6'd0, 6'($urandom_range(63))};
    phase_insert_pct = '{75, 60, 55, 70, 60, 50, 80, 55};
    phase_gaps       = '{1, 1, 1, 0, 1, 1, 1, 0};

    for (int ph = 0; ph < PHASES; ph++) begin
      // a write attempt with elements held must be dropped
      if (sb.held != 0) set_base_slot(6'($urandom_range(63)));
      // empty the array from the top so the lower bound can move
      while (sb.held != 0) begin
        send_op(KIND_DELETE, 6'(sb.base + sb.held - 1), $urandom);
        maybe_idle(phase_gaps[ph]);
      end
      set_base_slot(phase_base[ph]);
      repeat (PHASE_ITEMS) begin
        send_random_op(phase_insert_pct[ph]);
        maybe_idle(phase_gaps[ph]);
      end
    end

    // wind down: everything owed must arrive, then a quiet window
    start_i <= 1'b0;
    while (sb.results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.results_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ ordered_array_insert_delete_unit.f @@
+incdir+hdl
hdl/oaid_pkg.sv
hdl/oaid_ram.sv
hdl/oaid_check.sv
hdl/ordered_array_insert_delete_unit.sv
bench/ordered_array_insert_delete_unit_tb.sv
